FILE: hdl/ksttl_pkg.sv
// Shared types and constants for the keyed slot table with lifetimes.
// Holds the entry layout, action and register codes, and the control and status bundles.
// No dependencies.
`default_nettype none

package ksttl_pkg;

  // Action codes carried in the low bits of each input beat.
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_TICK   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // Configuration register indexes and their reset values.
  localparam int          CFG_IDX_W          = 8;
  localparam logic [7:0]  CFG_FIRST_EVICT    = 8'd0;
  localparam logic [7:0]  CFG_SECOND_EVICT   = 8'd1;
  localparam logic [7:0]  FIRST_EVICT_RESET  = 8'd5;
  localparam logic [7:0]  SECOND_EVICT_RESET = 8'd9;

  // Beat widths.
  localparam int IN_W  = 72;
  localparam int OUT_W = 16;

  // Stored entry; the valid bit lives in flip-flops beside the memory.
  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  mdata;
    logic [7:0]  coord_a;
    logic [7:0]  coord_b;
    logic [7:0]  etype;
    logic [7:0]  life;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // What a table scan does with each valid entry.
  typedef enum logic [1:0] {
    MODE_EVICT1,
    MODE_EVICT2,
    MODE_FIND,
    MODE_TICK
  } scan_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       wipe;
    logic       ins_wr;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] action;
    logic       full;
    logic       busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/ksttl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module ksttl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/ksttl_ctrl.sv
// Controller state machine for the keyed slot table.
// Sequences scans, eviction, insert and result hand-off; uses ksttl_pkg.
`default_nettype none

module ksttl_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  wire  ksttl_pkg::sts_t sts,
  output ksttl_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_INS_RD,
    ST_INS_WR,
    ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  ksttl_pkg::scan_mode_t   phase_r, phase_nxt;
  logic                    out_valid_r;

  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == ST_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (sts.action)
          ksttl_pkg::ACT_INSERT: begin
            if (sts.full) begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = ksttl_pkg::MODE_EVICT1;
              phase_nxt      = ksttl_pkg::MODE_EVICT1;
              state_nxt      = ST_SCAN;
            end else begin
              state_nxt = ST_INS_RD;
            end
          end
          ksttl_pkg::ACT_LOOKUP, ksttl_pkg::ACT_REMOVE: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = ksttl_pkg::MODE_FIND;
            phase_nxt      = ksttl_pkg::MODE_FIND;
            state_nxt      = ST_SCAN;
          end
          ksttl_pkg::ACT_TICK: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = ksttl_pkg::MODE_TICK;
            phase_nxt      = ksttl_pkg::MODE_TICK;
            state_nxt      = ST_SCAN;
          end
          ksttl_pkg::ACT_CLEAR: begin
            cmd.wipe  = 1'b1;
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        if (!sts.busy) begin
          case (phase_r)
            ksttl_pkg::MODE_EVICT1: begin
              if (sts.full) begin
                cmd.scan_start = 1'b1;
                cmd.scan_mode  = ksttl_pkg::MODE_EVICT2;
                phase_nxt      = ksttl_pkg::MODE_EVICT2;
              end else begin
                state_nxt = ST_INS_RD;
              end
            end
            ksttl_pkg::MODE_EVICT2: begin
              // Still full after both eviction passes: empty the table.
              cmd.wipe  = sts.full;
              state_nxt = ST_INS_RD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        state_nxt = ST_INS_WR;
      end
      ST_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, scan phase and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= ksttl_pkg::MODE_EVICT1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ksttl_dp.sv
// Datapath for the keyed slot table: entry and free-stack memories, valid bits,
// scan pipeline, counters and result registers. Uses ksttl_pkg and ksttl_ram.
`default_nettype none

module ksttl_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [ksttl_pkg::IN_W-1:0]   in_tdata,
  input  wire                          cfg_we,
  input  wire  [ksttl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [7:0]                   cfg_data,
  input  ksttl_pkg::cmd_t              cmd,
  output ksttl_pkg::sts_t              sts,
  output logic [ksttl_pkg::OUT_W-1:0]  out_tdata
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  // Item and configuration registers.
  logic [2:0]        action_r;
  ksttl_pkg::entry_t item_r;
  logic [7:0]        evict1_r, evict2_r;

  // Table state.
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [TABLE_ENTRIES-1:0] wrt_r, wrt_nxt;
  logic [CW-1:0]            used_r, used_nxt;

  // Scan pipeline.
  logic                  issue_act_r, rd_vld_r;
  logic [IW-1:0]         addr_r, rd_idx_r;
  ksttl_pkg::scan_mode_t mode_r;

  // Working result.
  logic          hit_r, hit_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] freed_r, freed_nxt;
  logic [ksttl_pkg::OUT_W-1:0] out_r;

  // Memory ports.
  logic [ksttl_pkg::ENTRY_W-1:0] ent_rdata, ent_wdata;
  logic                          ent_we;
  logic [IW-1:0]                 ent_waddr;
  logic [IW-1:0]                 stk_rdata, push_pos, used_idx, ins_slot;
  logic                          rel;

  ksttl_pkg::entry_t ent, ent_wr;
  logic [7:0]        tsel, new_life;
  logic              ent_ok, match, found;

  assign ent      = ksttl_pkg::entry_t'(ent_rdata);
  assign used_idx = used_r[IW-1:0];
  assign push_pos = IW'(used_r - CW'(1));
  assign ins_slot = wrt_r[used_idx] ? stk_rdata : used_idx;

  // Evaluation of the entry read back from memory.
  always_comb begin
    tsel     = (mode_r == ksttl_pkg::MODE_EVICT1) ? evict1_r : evict2_r;
    new_life = ent.life - 8'd1;
    ent_ok   = rd_vld_r && valid_r[rd_idx_r];
    match    = (ent.key == item_r.key) && (ent.mdata == item_r.mdata) &&
               (ent.coord_a == item_r.coord_a) && (ent.coord_b == item_r.coord_b) &&
               (ent.etype == item_r.etype);
    found    = ent_ok && (mode_r == ksttl_pkg::MODE_FIND) && match;
    case (mode_r)
      ksttl_pkg::MODE_EVICT1, ksttl_pkg::MODE_EVICT2: rel = ent_ok && (ent.etype == tsel);
      ksttl_pkg::MODE_FIND: rel = found && (action_r == ksttl_pkg::ACT_REMOVE);
      ksttl_pkg::MODE_TICK: rel = ent_ok && ((new_life == 8'd0) || new_life[7]);
      default:              rel = 1'b0;
    endcase
  end

  // Entry memory write: lifetime write-back on tick, new entry on insert.
  always_comb begin
    ent_wr      = ent;
    ent_wr.life = new_life;
    ent_we      = cmd.ins_wr || (ent_ok && (mode_r == ksttl_pkg::MODE_TICK));
    ent_waddr   = cmd.ins_wr ? ins_slot : rd_idx_r;
    ent_wdata   = cmd.ins_wr ? item_r : ent_wr;
  end

  ksttl_ram #(.WIDTH(ksttl_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (addr_r),
    .rdata (ent_rdata)
  );

  // Free-slot stack; a position never written since clear reads as its own index.
  ksttl_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_stack_ram (
    .clk   (clk),
    .we    (rel && (used_r != '0)),
    .waddr (push_pos),
    .wdata (rd_idx_r),
    .raddr (used_idx),
    .rdata (stk_rdata)
  );

  // Next table state and working result.
  always_comb begin
    valid_nxt = valid_r;
    wrt_nxt   = wrt_r;
    used_nxt  = used_r;
    hit_nxt   = hit_r;
    slot_nxt  = slot_r;
    freed_nxt = freed_r;
    if (cmd.load_item) begin
      hit_nxt   = 1'b0;
      slot_nxt  = '0;
      freed_nxt = '0;
    end
    if (rel) begin
      valid_nxt[rd_idx_r] = 1'b0;
      freed_nxt           = freed_r + CW'(1);
      if (used_r != '0) begin
        used_nxt          = used_r - CW'(1);
        wrt_nxt[push_pos] = 1'b1;
      end
    end
    if (found) begin
      hit_nxt  = 1'b1;
      slot_nxt = rd_idx_r;
    end
    if (cmd.wipe) begin
      freed_nxt = freed_r + used_r;
      used_nxt  = '0;
      valid_nxt = '0;
      wrt_nxt   = '0;
    end
    if (cmd.ins_wr) begin
      valid_nxt[ins_slot] = 1'b1;
      used_nxt            = used_r + CW'(1);
      hit_nxt             = 1'b1;
      slot_nxt            = ins_slot;
    end
  end

  // Control state: table bookkeeping, scan pipeline, configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      wrt_r       <= '0;
      used_r      <= '0;
      issue_act_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      addr_r      <= '0;
      mode_r      <= ksttl_pkg::MODE_EVICT1;
      evict1_r    <= ksttl_pkg::FIRST_EVICT_RESET;
      evict2_r    <= ksttl_pkg::SECOND_EVICT_RESET;
    end else begin
      valid_r <= valid_nxt;
      wrt_r   <= wrt_nxt;
      used_r  <= used_nxt;
      if (cfg_we && (cfg_index == ksttl_pkg::CFG_FIRST_EVICT)) begin
        evict1_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == ksttl_pkg::CFG_SECOND_EVICT)) begin
        evict2_r <= cfg_data;
      end
      if (cmd.scan_start) begin
        issue_act_r <= 1'b1;
        rd_vld_r    <= 1'b0;
        addr_r      <= '0;
        mode_r      <= cmd.scan_mode;
      end else begin
        rd_vld_r <= issue_act_r && !found;
        if (issue_act_r) begin
          if (found || (addr_r == LAST_IDX)) begin
            issue_act_r <= 1'b0;
          end else begin
            addr_r <= addr_r + IW'(1);
          end
        end
      end
    end
  end

  // Payload registers: item fields with offsets applied, scan index, results.
  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    hit_r    <= hit_nxt;
    slot_r   <= slot_nxt;
    freed_r  <= freed_nxt;
    if (cmd.load_item) begin
      action_r      <= in_tdata[2:0];
      item_r.key    <= in_tdata[18:3];
      item_r.mdata  <= in_tdata[26:19];
      item_r.coord_a <= in_tdata[34:27] + {4'd0, in_tdata[50:47]} - 8'd1;
      item_r.coord_b <= in_tdata[42:35] + {6'd0, in_tdata[44:43]} - 8'd1;
      item_r.etype  <= in_tdata[58:51];
      item_r.life   <= in_tdata[66:59];
    end
    if (cmd.out_load) begin
      out_r <= {2'b00, 7'(freed_r), 6'(slot_r), hit_r};
    end
  end

  assign out_tdata  = out_r;
  assign sts.action = action_r;
  assign sts.full   = (used_r == FULL_CNT);
  assign sts.busy   = issue_act_r || rd_vld_r;

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_CNT) else $error("used count above table size");

  // Insert only lands on a free slot.
  a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> !valid_r[ins_slot]) else $error("insert onto a valid slot");

  // A wipe leaves the table empty.
  a_wipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wipe |=> (used_r == '0) && (valid_r == '0)) else $error("wipe left entries");

  // A match ends the scan at once.
  a_found_stop: assert property (@(posedge clk) disable iff (!rst_n)
    found |=> !sts.busy) else $error("scan continued after match");

endmodule

`default_nettype wire

FILE: hdl/keyed_slot_table_with_ttl.sv
// Keyed slot table with lifetimes. Lookup, remove and tick scan one entry per cycle;
// a full-table insert adds up to two such scans.
// One item is in work at a time: the next beat is taken in the cycle after the result
// is loaded.
// Synchronous active-low reset empties the table at once (valid bits in flip-flops).
`default_nettype none

module keyed_slot_table_with_ttl #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // action[2:0], key_id[18:3], map_data[26:19], map_a[34:27], map_b[42:35],
  // offset_code[50:43], entry_type[58:51], lifetime[66:59], zeros above
  input  wire  [ksttl_pkg::IN_W-1:0]       in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // hit[0], slot[6:1], freed_count[13:7], zeros above
  output logic [ksttl_pkg::OUT_W-1:0]      out_tdata,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ksttl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [7:0]                       cfg_data
);

  ksttl_pkg::cmd_t cmd;
  ksttl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ksttl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ksttl_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

FILE: test/keyed_slot_table_with_ttl_test.sv
// Self-checking testbench for the keyed slot table with lifetimes.
// Drives insert, lookup, remove, tick and clear beats, predicts every result
// beat in a local table model, and depends on ksttl_pkg and the top module.
`timescale 1ns / 100ps

module keyed_slot_table_with_ttl_test;

  localparam int N_SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // Item fields as driven on the input stream.
  typedef struct packed {
    logic [7:0]  lifetime;
    logic [7:0]  etype;
    logic [7:0]  ocode;
    logic [7:0]  mb;
    logic [7:0]  ma;
    logic [7:0]  mdata;
    logic [15:0] key;
    logic [2:0]  action;
  } table_op_t;

  localparam int OP_W = $bits(table_op_t);

  // Result fields as they appear on the output stream.
  typedef struct packed {
    logic [6:0] freed;
    logic [5:0] slot;
    logic       hit;
  } table_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ksttl_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ksttl_pkg::OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ksttl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  always #5 clk = ~clk;

  keyed_slot_table_with_ttl #(.TABLE_ENTRIES(N_SLOTS)) u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Local copy of the table state.
  logic                mdl_valid [N_SLOTS];
  ksttl_pkg::entry_t   mdl_entry [N_SLOTS];
  logic [5:0]          mdl_free  [N_SLOTS];
  int                  mdl_used;
  logic [7:0]          mdl_evict1, mdl_evict2;

  table_resp_t expected_resps[$];
  int          n_errors = 0;
  int          n_resps = 0;
  int          idle_in_pct = 0;
  int          idle_out_pct = 0;
  int          stall_cycles = 0;
  int          n_evictions = 0;

  // Recently inserted items, so lookups and removes usually hit.
  table_op_t   recent_ops[$];

  function automatic void tbl_release(int i);
    mdl_valid[i] = 1'b0;
    mdl_entry[i] = '0;
    if (mdl_used > 0) begin
      mdl_used--;
      mdl_free[mdl_used] = i[5:0];
    end
  endfunction

  function automatic int tbl_wipe();
    int n;
    n = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (mdl_valid[i]) n++;
      mdl_valid[i] = 1'b0;
      mdl_entry[i] = '0;
      mdl_free[i] = i[5:0];
    end
    mdl_used = 0;
    return n;
  endfunction

  function automatic int tbl_evict(logic [7:0] t);
    int n;
    n = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (mdl_valid[i] && mdl_entry[i].etype == t) begin
        tbl_release(i);
        n++;
      end
    end
    return n;
  endfunction

  // Predict the result of one item and update the table copy.
  function automatic table_resp_t tbl_apply(table_op_t op);
    table_resp_t       r;
    ksttl_pkg::entry_t e;
    int                freed, m, s;
    logic [7:0]        nl;
    r = '0;
    freed = 0;
    m = -1;
    e.key = op.key;
    e.mdata = op.mdata;
    e.coord_a = op.ma + {4'd0, op.ocode[7:4]} - 8'd1;
    e.coord_b = op.mb + {6'd0, op.ocode[1:0]} - 8'd1;
    e.etype = op.etype;
    e.life = op.lifetime;
    if (op.action == ksttl_pkg::ACT_LOOKUP || op.action == ksttl_pkg::ACT_REMOVE) begin
      for (int i = N_SLOTS - 1; i >= 0; i--)
        if (mdl_valid[i] &&
            mdl_entry[i][ksttl_pkg::ENTRY_W-1:8] == e[ksttl_pkg::ENTRY_W-1:8]) m = i;
    end
    case (op.action)
      ksttl_pkg::ACT_INSERT: begin
        if (mdl_used >= N_SLOTS) begin
          n_evictions++;
          freed += tbl_evict(mdl_evict1);
          if (mdl_used >= N_SLOTS) begin
            freed += tbl_evict(mdl_evict2);
            if (mdl_used >= N_SLOTS) freed += tbl_wipe();
          end
        end
        s = mdl_free[mdl_used];
        mdl_used++;
        mdl_valid[s] = 1'b1;
        mdl_entry[s] = e;
        r.hit = 1'b1;
        r.slot = s[5:0];
      end
      ksttl_pkg::ACT_LOOKUP: begin
        if (m >= 0) begin
          r.hit = 1'b1;
          r.slot = m[5:0];
        end
      end
      ksttl_pkg::ACT_REMOVE: begin
        if (m >= 0) begin
          r.hit = 1'b1;
          r.slot = m[5:0];
          tbl_release(m);
          freed = 1;
        end
      end
      ksttl_pkg::ACT_TICK: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (mdl_valid[i]) begin
            nl = mdl_entry[i].life - 8'd1;
            mdl_entry[i].life = nl;
            if (nl == 8'd0 || nl[7]) begin
              tbl_release(i);
              freed++;
            end
          end
        end
      end
      ksttl_pkg::ACT_CLEAR: freed = tbl_wipe();
      default: ;
    endcase
    r.freed = freed[6:0];
    return r;
  endfunction

  // Send one item; predicts at acceptance.
  task automatic send_op(table_op_t op);
    // Start at a falling edge after the previous beat was dropped.
    @(negedge clk);
    while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= ksttl_pkg::IN_W'(op);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_resps.push_back(tbl_apply(op));
    if (op.action == ksttl_pkg::ACT_INSERT) begin
      recent_ops.push_back(op);
      if (recent_ops.size() > 80) void'(recent_ops.pop_front());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_resps.size() != 0) @(negedge clk);
    // A scan may still be finishing; let the table settle.
    repeat (3 * N_SLOTS + 20) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    // Start at a falling edge after the previous write was dropped.
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ksttl_pkg::CFG_FIRST_EVICT) mdl_evict1 = val;
    else if (idx == ksttl_pkg::CFG_SECOND_EVICT) mdl_evict2 = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic table_op_t rand_op();
    table_op_t op;
    op = OP_W'({$urandom, $urandom, $urandom});
    return op;
  endfunction

  // Random op biased toward a small key space and toward recent inserts.
  function automatic table_op_t pick_op();
    table_op_t op;
    int        sel;
    op = rand_op();
    sel = $urandom_range(99);
    if (sel < 40) op.action = ksttl_pkg::ACT_INSERT;
    else if (sel < 60) op.action = ksttl_pkg::ACT_LOOKUP;
    else if (sel < 80) op.action = ksttl_pkg::ACT_REMOVE;
    else if (sel < 92) op.action = ksttl_pkg::ACT_TICK;
    else if (sel < 95) op.action = ksttl_pkg::ACT_CLEAR;
    else op.action = 3'($urandom_range(7, 5));
    if ($urandom_range(3) != 0) begin
      op.key[15:3] = '0;
      op.etype = 8'($urandom_range(3) == 0 ? mdl_evict1 : $urandom_range(3));
      op.lifetime = 8'($urandom_range(8) == 0 ? $urandom : $urandom_range(1, 12));
    end
    if ((op.action == ksttl_pkg::ACT_LOOKUP || op.action == ksttl_pkg::ACT_REMOVE) &&
        recent_ops.size() > 0 && $urandom_range(3) != 0) begin
      op = recent_ops[$urandom_range(recent_ops.size() - 1)];
      op.action = $urandom_range(1) ? ksttl_pkg::ACT_LOOKUP : ksttl_pkg::ACT_REMOVE;
    end
    return op;
  endfunction

  // Result checker and receiver stall control.
  always @(posedge clk) begin
    table_resp_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = table_resp_t'(out_tdata[13:0]);
      n_resps++;
      if (out_tdata[ksttl_pkg::OUT_W-1:14] != '0) begin
        $error("padding: expected 0, got %h", out_tdata[ksttl_pkg::OUT_W-1:14]);
        n_errors++;
      end
      if (expected_resps.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        n_errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (got.hit != exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, got.hit);
          n_errors++;
        end
        if (got.slot != exp_r.slot) begin
          $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
          n_errors++;
        end
        if (got.freed != exp_r.freed) begin
          $error("freed_count: expected %0d, got %0d", exp_r.freed, got.freed);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk)
    out_tready <= !(idle_out_pct > 0 && $urandom_range(99) < idle_out_pct);

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("keyed_slot_table_with_ttl regression: fail");
      $finish;
    end
  end

  // Directed: extremes, every action, miss paths and unused codes.
  task automatic test_directed();
    table_op_t op;
    op = '1;
    op.action = ksttl_pkg::ACT_INSERT;
    send_op(op);
    op.action = ksttl_pkg::ACT_LOOKUP;
    send_op(op);
    op.action = ksttl_pkg::ACT_REMOVE;
    send_op(op);
    send_op(op);
    op = '0;
    op.lifetime = 8'd1;
    send_op(op);
    op.action = ksttl_pkg::ACT_LOOKUP;
    send_op(op);
    op.lifetime = 8'd0;
    op.action = ksttl_pkg::ACT_INSERT;
    send_op(op);
    op.lifetime = 8'h80;
    op.ocode = 8'hF3;
    send_op(op);
    op.lifetime = 8'h7F;
    op.ocode = 8'h0C;
    send_op(op);
    op.action = ksttl_pkg::ACT_TICK;
    send_op(op);
    op.action = ksttl_pkg::ACT_LOOKUP;
    send_op(op);
    for (int a = 5; a < 8; a++) begin
      op = rand_op();
      op.action = 3'(a);
      send_op(op);
    end
    op.action = ksttl_pkg::ACT_CLEAR;
    send_op(op);
    send_op(op);
  endtask

  // Fill the table to force both eviction passes and the full wipe.
  task automatic test_full_table(logic [7:0] t1, logic [7:0] t2);
    table_op_t op;
    wait_drain();
    write_reg(ksttl_pkg::CFG_FIRST_EVICT, t1);
    write_reg(ksttl_pkg::CFG_SECOND_EVICT, t2);
    write_reg(8'd2 + 8'($urandom_range(253)), 8'($urandom));
    for (int k = 0; k < N_SLOTS + 6; k++) begin
      op = rand_op();
      op.action = ksttl_pkg::ACT_INSERT;
      op.etype = (k % 5 == 0) ? t1 : (k % 7 == 0) ? t2 : 8'($urandom);
      send_op(op);
    end
    op.action = ksttl_pkg::ACT_CLEAR;
    send_op(op);
    for (int k = 0; k < N_SLOTS + 2; k++) begin
      op = rand_op();
      op.action = ksttl_pkg::ACT_INSERT;
      op.etype = t1 ^ 8'h01;
      if (op.etype == t2) op.etype = t1 ^ 8'h02;
      send_op(op);
    end
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 150 == 149) begin
        wait_drain();
        write_reg(ksttl_pkg::CFG_FIRST_EVICT, 8'($urandom_range(3)));
        write_reg(ksttl_pkg::CFG_SECOND_EVICT, 8'($urandom));
      end
      send_op(pick_op());
    end
  endtask

  initial begin
    void'(tbl_wipe());
    mdl_evict1 = ksttl_pkg::FIRST_EVICT_RESET;
    mdl_evict2 = ksttl_pkg::SECOND_EVICT_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_in_pct = 25;
    idle_out_pct = 76;
    test_directed();
    test_full_table(8'd0, 8'd255);
    test_random(300);
    idle_in_pct = 76;
    idle_out_pct = 25;
    test_full_table(8'd255, 8'd0);
    test_random(300);
    idle_in_pct = 0;
    idle_out_pct = 0;
    test_random(300);
    wait_drain();

    $display("Covered all actions, unused codes, full-table evictions and wipes,");
    $display("%0d result beats, %0d full-table inserts.", n_resps, n_evictions);
    if (n_errors == 0) begin
      $display("keyed_slot_table_with_ttl regression: pass");
    end else begin
      $display("keyed_slot_table_with_ttl regression: fail");
    end
    $finish;
  end

endmodule
